// ===== rtl/color_mask_centroid_assert.svh =====
// Assertion macros for the color mask and centroid block.
// Included by the top level; needs no package.
`ifndef COLOR_MASK_CENTROID_ASSERT_SVH
`define COLOR_MASK_CENTROID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle implication failed.");

// The consequent must hold in the cycle after the antecedent.
`define CMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle implication failed.");

`endif

// ===== rtl/cmc_pkg.sv =====
// Shared types and constants for the color mask and centroid block.
// Used by every module of the block; depends on nothing.
package cmc_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 512;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam int CHAN_W   = 8;
   localparam int MARGIN_W = 8;
   localparam int COUNT_W  = 20;
   localparam int CSUM_W   = 30;
   localparam int RSUM_W   = 29;
   localparam int CX_W     = 14;
   localparam int CY_W     = 13;
   localparam int FRAC_W   = 4;

   localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(MAX_WIDTH - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(MAX_HEIGHT - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CSUM_W-1:0]  CSUM_MAX  = '1;
   localparam logic [RSUM_W-1:0]  RSUM_MAX  = '1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COUNT_W;

   localparam logic [MARGIN_W-1:0] RED_MARGIN_RESET  = 8'd40;
   localparam logic [MARGIN_W-1:0] BLUE_MARGIN_RESET = 8'd30;
   localparam logic [COUNT_W-1:0]  PRESENCE_RESET    = 20'd100;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS  = CX_W;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RED_MARGIN  = 2'd0,
      CSR_BLUE_MARGIN = 2'd1,
      CSR_PRESENCE    = 2'd2
   } cmc_csr_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE
   } cmc_back_state_type;

   typedef struct packed {
      logic               red_mask;
      logic               not_blue_mask;
      logic               frame_end;
      logic [COUNT_W-1:0] count;
      logic [CSUM_W-1:0]  col_sum;
      logic [RSUM_W-1:0]  row_sum;
   } cmc_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cmc_qstat_type;

endpackage

// ===== rtl/cmc_front.sv =====
// Front end: classifies each pixel and keeps the raster position and frame totals.
// Depends on cmc_pkg; feeds cmc_queue.
module cmc_front import cmc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [CHAN_W-1:0]   req_pixel_blue,
   input  logic [CHAN_W-1:0]   req_pixel_green,
   input  logic [CHAN_W-1:0]   req_pixel_red,
   input  logic                req_last_in_line,
   input  logic                req_last_in_frame,
   input  logic [MARGIN_W-1:0] red_margin,
   input  logic [MARGIN_W-1:0] blue_margin,
   input  cmc_qstat_type       q_stat,
   output logic                push,
   output cmc_entry_type       entry
);

   localparam int CMP_W  = CHAN_W + 1;
   localparam int CSUM_EW = CSUM_W + 1;
   localparam int RSUM_EW = RSUM_W + 1;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CSUM_W-1:0]  csum_ff, csum_in;
   logic [RSUM_W-1:0]  rsum_ff, rsum_in;

   logic [CMP_W-1:0]   r_ext, g_ext, b_ext;
   logic               is_red, is_blue;
   logic [CSUM_EW-1:0] csum_add;
   logic [RSUM_EW-1:0] rsum_add;
   logic [COUNT_W-1:0] count_upd;
   logic [CSUM_W-1:0]  csum_upd;
   logic [RSUM_W-1:0]  rsum_upd;

   always_comb begin
      r_ext   = {1'b0, req_pixel_red};
      g_ext   = {1'b0, req_pixel_green};
      b_ext   = {1'b0, req_pixel_blue};
      is_red  = (r_ext > b_ext + CMP_W'(red_margin)) && (r_ext > g_ext + CMP_W'(red_margin));
      is_blue = (b_ext > r_ext + CMP_W'(blue_margin)) && (b_ext > g_ext + CMP_W'(blue_margin));

      csum_add = {1'b0, csum_ff} + CSUM_EW'(col_ff);
      rsum_add = {1'b0, rsum_ff} + RSUM_EW'(row_ff);

      count_upd = count_ff;
      csum_upd  = csum_ff;
      rsum_upd  = rsum_ff;
      if (is_red) begin
         if (count_ff != COUNT_MAX) begin
            count_upd = count_ff + COUNT_W'(1);
         end
         csum_upd = csum_add[CSUM_W] ? CSUM_MAX : csum_add[CSUM_W-1:0];
         rsum_upd = rsum_add[RSUM_W] ? RSUM_MAX : rsum_add[RSUM_W-1:0];
      end

      push                = req_valid && !q_stat.full;
      entry.red_mask      = is_red;
      entry.not_blue_mask = !is_blue;
      entry.frame_end     = req_last_in_frame;
      entry.count         = count_upd;
      entry.col_sum       = csum_upd;
      entry.row_sum       = rsum_upd;

      col_in   = col_ff;
      row_in   = row_ff;
      count_in = count_ff;
      csum_in  = csum_ff;
      rsum_in  = rsum_ff;
      if (push) begin
         if (req_last_in_frame) begin
            col_in   = '0;
            row_in   = '0;
            count_in = '0;
            csum_in  = '0;
            rsum_in  = '0;
         end else begin
            count_in = count_upd;
            csum_in  = csum_upd;
            rsum_in  = rsum_upd;
            if (req_last_in_line) begin
               col_in = '0;
               if (row_ff != ROW_LAST) begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else if (col_ff != COL_LAST) begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         count_ff <= '0;
         csum_ff  <= '0;
         rsum_ff  <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         count_ff <= count_in;
         csum_ff  <= csum_in;
         rsum_ff  <= rsum_in;
      end
   end

endmodule

// ===== rtl/cmc_queue.sv =====
// Short queue of classified pixels between the front and back ends.
// Depends on cmc_pkg.
module cmc_queue import cmc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmc_entry_type push_entry,
   input  logic          pop,
   output cmc_entry_type head,
   output cmc_qstat_type q_stat
);

   cmc_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      q_stat.empty = (fill_ff == '0);
      q_stat.full  = (fill_ff == QCNT_W'(QUEUE_DEPTH));
      head         = slot_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/cmc_divider.sv =====
// Radix-2 restoring divider that forms both centroid coordinates at once.
// Depends on cmc_pkg; used by cmc_back.
module cmc_divider import cmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CSUM_W-1:0]  col_sum,
   input  logic [RSUM_W-1:0]  row_sum,
   input  logic [COUNT_W-1:0] count,
   output logic               busy,
   output logic [CX_W-1:0]    quot_x,
   output logic [CY_W-1:0]    quot_y
);

   localparam int LOW_W  = CX_W - FRAC_W;
   localparam int SATY_W = CY_W - FRAC_W;
   localparam int REM_EW = COUNT_W + 1;

   logic                  busy_ff, busy_in;
   logic [DIV_STEP_W-1:0] steps_ff, steps_in;
   logic [COUNT_W-1:0]    div_ff, div_in;
   logic [COUNT_W-1:0]    rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [DIV_STEPS-1:0]  low_x_ff, low_x_in, low_y_ff, low_y_in;
   logic [DIV_STEPS-1:0]  q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic                  sat_x_ff, sat_x_in, sat_y_ff, sat_y_in;

   logic [REM_EW-1:0]     trial_x, trial_y;
   logic                  ge_x, ge_y;

   always_comb begin
      trial_x = {rem_x_ff, low_x_ff[DIV_STEPS-1]};
      trial_y = {rem_y_ff, low_y_ff[DIV_STEPS-1]};
      ge_x    = trial_x >= {1'b0, div_ff};
      ge_y    = trial_y >= {1'b0, div_ff};

      busy_in  = busy_ff;
      steps_in = steps_ff;
      div_in   = div_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      low_x_in = low_x_ff;
      low_y_in = low_y_ff;
      q_x_in   = q_x_ff;
      q_y_in   = q_y_ff;
      sat_x_in = sat_x_ff;
      sat_y_in = sat_y_ff;

      if (start) begin
         busy_in  = 1'b1;
         steps_in = DIV_STEP_W'(DIV_STEPS);
         div_in   = count;
         rem_x_in = COUNT_W'(col_sum[CSUM_W-1:LOW_W]);
         rem_y_in = COUNT_W'(row_sum[RSUM_W-1:LOW_W]);
         low_x_in = {col_sum[LOW_W-1:0], FRAC_W'(0)};
         low_y_in = {row_sum[LOW_W-1:0], FRAC_W'(0)};
         q_x_in   = '0;
         q_y_in   = '0;
         sat_x_in = COUNT_W'(col_sum[CSUM_W-1:LOW_W]) >= count;
         sat_y_in = COUNT_W'(row_sum[RSUM_W-1:SATY_W]) >= count;
      end else if (busy_ff) begin
         rem_x_in = ge_x ? COUNT_W'(trial_x - {1'b0, div_ff}) : trial_x[COUNT_W-1:0];
         rem_y_in = ge_y ? COUNT_W'(trial_y - {1'b0, div_ff}) : trial_y[COUNT_W-1:0];
         low_x_in = {low_x_ff[DIV_STEPS-2:0], 1'b0};
         low_y_in = {low_y_ff[DIV_STEPS-2:0], 1'b0};
         q_x_in   = {q_x_ff[DIV_STEPS-2:0], ge_x};
         q_y_in   = {q_y_ff[DIV_STEPS-2:0], ge_y};
         steps_in = steps_ff - DIV_STEP_W'(1);
         busy_in  = (steps_ff != DIV_STEP_W'(1));
      end

      busy   = busy_ff;
      quot_x = sat_x_ff ? '1 : q_x_ff[CX_W-1:0];
      quot_y = sat_y_ff ? '1 : q_y_ff[CY_W-1:0];
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      div_ff   <= div_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      low_x_ff <= low_x_in;
      low_y_ff <= low_y_in;
      q_x_ff   <= q_x_in;
      q_y_ff   <= q_y_in;
      sat_x_ff <= sat_x_in;
      sat_y_ff <= sat_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== rtl/cmc_back.sv =====
// Back end: drains the queue, runs frame-end centroid division, and drives the result register.
// Depends on cmc_pkg and cmc_divider.
module cmc_back import cmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmc_qstat_type      q_stat,
   input  cmc_entry_type      head,
   output logic               pop,
   input  logic [COUNT_W-1:0] presence_threshold,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_red_mask,
   output logic               rsp_not_blue_mask,
   output logic               rsp_frame_done,
   output logic [COUNT_W-1:0] rsp_red_count,
   output logic               rsp_object_present,
   output logic [CX_W-1:0]    rsp_centroid_x,
   output logic [CY_W-1:0]    rsp_centroid_y,
   output logic               rsp_centroid_fresh
);

   cmc_back_state_type state_ff, state_in;
   cmc_entry_type      cur_ff, cur_in;
   logic [CX_W-1:0]    held_x_ff, held_x_in;
   logic [CY_W-1:0]    held_y_ff, held_y_in;

   logic               valid_ff, valid_in;
   logic               red_ff, red_in;
   logic               not_blue_ff, not_blue_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               present_ff, present_in;
   logic [CX_W-1:0]    cx_ff, cx_in;
   logic [CY_W-1:0]    cy_ff, cy_in;
   logic               fresh_ff, fresh_in;

   logic               out_free;
   logic               div_start;
   logic               div_busy;
   logic [CX_W-1:0]    quot_x;
   logic [CY_W-1:0]    quot_y;

   cmc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .col_sum (head.col_sum),
      .row_sum (head.row_sum),
      .count   (head.count),
      .busy    (div_busy),
      .quot_x  (quot_x),
      .quot_y  (quot_y)
   );

   always_comb begin
      out_free    = !valid_ff || !rsp_stall;
      pop         = 1'b0;
      div_start   = 1'b0;
      state_in    = state_ff;
      cur_in      = cur_ff;
      held_x_in   = held_x_ff;
      held_y_in   = held_y_ff;
      valid_in    = valid_ff && rsp_stall;
      red_in      = red_ff;
      not_blue_in = not_blue_ff;
      done_in     = done_ff;
      count_in    = count_ff;
      present_in  = present_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      fresh_in    = fresh_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty && out_free) begin
               pop = 1'b1;
               if (head.frame_end && head.count != '0) begin
                  div_start = 1'b1;
                  cur_in    = head;
                  state_in  = BK_DIVIDE;
               end else begin
                  valid_in    = 1'b1;
                  red_in      = head.red_mask;
                  not_blue_in = head.not_blue_mask;
                  done_in     = head.frame_end;
                  count_in    = head.frame_end ? head.count : '0;
                  present_in  = head.frame_end && (head.count > presence_threshold);
                  cx_in       = head.frame_end ? held_x_ff : '0;
                  cy_in       = head.frame_end ? held_y_ff : '0;
                  fresh_in    = 1'b0;
               end
            end
         end
         BK_DIVIDE: begin
            if (!div_busy && out_free) begin
               valid_in    = 1'b1;
               red_in      = cur_ff.red_mask;
               not_blue_in = cur_ff.not_blue_mask;
               done_in     = 1'b1;
               count_in    = cur_ff.count;
               present_in  = cur_ff.count > presence_threshold;
               cx_in       = quot_x;
               cy_in       = quot_y;
               fresh_in    = 1'b1;
               held_x_in   = quot_x;
               held_y_in   = quot_y;
               state_in    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid          = valid_ff;
      rsp_red_mask       = red_ff;
      rsp_not_blue_mask  = not_blue_ff;
      rsp_frame_done     = done_ff;
      rsp_red_count      = count_ff;
      rsp_object_present = present_ff;
      rsp_centroid_x     = cx_ff;
      rsp_centroid_y     = cy_ff;
      rsp_centroid_fresh = fresh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         valid_ff  <= 1'b0;
         held_x_ff <= '0;
         held_y_ff <= '0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      red_ff      <= red_in;
      not_blue_ff <= not_blue_in;
      done_ff     <= done_in;
      count_ff    <= count_in;
      present_ff  <= present_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      fresh_ff    <= fresh_in;
   end

endmodule

// ===== rtl/color_mask_centroid.sv =====
// Pixels are accepted one per cycle while the 4-entry queue between the front and back ends
// has room; every pixel yields one result transaction with its red and not-blue mask bits.
// The last pixel of a frame also carries the frame totals. When the frame holds red pixels,
// the back end takes that transaction, runs the 14 steps of the shared restoring divider,
// and then loads the result. With the result side ready, a steady pixel stream therefore
// stalls after each such frame end once the queue has filled. Depends on cmc_pkg and the
// assertion macros header.
`include "color_mask_centroid_assert.svh"

module color_mask_centroid import cmc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAN_W-1:0]     req_pixel_blue,
   input  logic [CHAN_W-1:0]     req_pixel_green,
   input  logic [CHAN_W-1:0]     req_pixel_red,
   input  logic                  req_last_in_line,
   input  logic                  req_last_in_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_red_mask,
   output logic                  rsp_not_blue_mask,
   output logic                  rsp_frame_done,
   output logic [COUNT_W-1:0]    rsp_red_count,
   output logic                  rsp_object_present,
   output logic [CX_W-1:0]       rsp_centroid_x,
   output logic [CY_W-1:0]       rsp_centroid_y,
   output logic                  rsp_centroid_fresh,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [MARGIN_W-1:0] red_margin_ff, red_margin_in;
   logic [MARGIN_W-1:0] blue_margin_ff, blue_margin_in;
   logic [COUNT_W-1:0]  presence_ff, presence_in;

   cmc_qstat_type q_stat;
   cmc_entry_type push_entry;
   cmc_entry_type head;
   logic          push;
   logic          pop;

   always_comb begin
      csr_ready      = 1'b1;
      red_margin_in  = red_margin_ff;
      blue_margin_in = blue_margin_ff;
      presence_in    = presence_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RED_MARGIN:  red_margin_in  = csr_wdata[MARGIN_W-1:0];
            CSR_BLUE_MARGIN: blue_margin_in = csr_wdata[MARGIN_W-1:0];
            CSR_PRESENCE:    presence_in    = csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
      req_stall = q_stat.full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_margin_ff  <= RED_MARGIN_RESET;
         blue_margin_ff <= BLUE_MARGIN_RESET;
         presence_ff    <= PRESENCE_RESET;
      end else begin
         red_margin_ff  <= red_margin_in;
         blue_margin_ff <= blue_margin_in;
         presence_ff    <= presence_in;
      end
   end

   cmc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_pixel_blue    (req_pixel_blue),
      .req_pixel_green   (req_pixel_green),
      .req_pixel_red     (req_pixel_red),
      .req_last_in_line  (req_last_in_line),
      .req_last_in_frame (req_last_in_frame),
      .red_margin        (red_margin_ff),
      .blue_margin       (blue_margin_ff),
      .q_stat            (q_stat),
      .push              (push),
      .entry             (push_entry)
   );

   cmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   cmc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_stat             (q_stat),
      .head               (head),
      .pop                (pop),
      .presence_threshold (presence_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red_mask       (rsp_red_mask),
      .rsp_not_blue_mask  (rsp_not_blue_mask),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_red_count      (rsp_red_count),
      .rsp_object_present (rsp_object_present),
      .rsp_centroid_x     (rsp_centroid_x),
      .rsp_centroid_y     (rsp_centroid_y),
      .rsp_centroid_fresh (rsp_centroid_fresh)
   );

   `CMC_ASSERT_IMPLIES(a_totals_only_at_frame_end, clock, reset, rsp_valid && !rsp_frame_done, rsp_red_count == '0 && !rsp_object_present && !rsp_centroid_fresh && rsp_centroid_x == '0 && rsp_centroid_y == '0)
   `CMC_ASSERT_IMPLIES(a_fresh_needs_red_pixels, clock, reset, rsp_valid && rsp_centroid_fresh, rsp_frame_done && rsp_red_count != '0)
   `CMC_ASSERT_IMPLIES(a_present_needs_count, clock, reset, rsp_valid && rsp_object_present, rsp_red_count > presence_ff)
   `CMC_ASSERT_NEXT(a_reset_empties_block, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule
